// ===== sv/stereo_chorus_modulated_delay_defines.svh =====
// ----------------------------------------------------------------------------
// Stereo chorus assertion macros
// Shared assertion macros for the chorus modules. Both expect clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef STEREO_CHORUS_MODULATED_DELAY_DEFINES_SVH
`define STEREO_CHORUS_MODULATED_DELAY_DEFINES_SVH
`ifndef SYNTHESIS
`define SCMD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scmd: same-cycle check failed");
`define SCMD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scmd: next-cycle check failed");
`else
`define SCMD_ASSERT_SAME(lbl, ante, cons)
`define SCMD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/scmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo chorus package
// Sizes, voice constants, sine table builder and controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package scmd_pkg;

	localparam int DELAY_DEPTH = 1024;
	localparam int DLY_AW = $clog2(DELAY_DEPTH);
	localparam int POS_W = DLY_AW + 16;
	localparam int SINE_DEPTH = 1024;
	localparam int SIN_AW = $clog2(SINE_DEPTH);
	localparam int NUM_VOICES = 6;
	localparam int NUM_TAPS = 3;
	localparam int MID_TAP = 1;
	localparam int VOICE_W = 3;
	localparam int GAIN_W = 24;
	localparam logic [GAIN_W-1:0] GAIN_TOP = '1;

	localparam logic [15:0] RST_VG_START = 16'd0;
	localparam logic [15:0] RST_VG_STEP = 16'd0;
	localparam logic [15:0] RST_MG_START = 16'd16384;
	localparam logic [15:0] RST_MG_STEP = 16'd0;
	localparam logic [15:0] RST_TAP_RANGE = 16'd41779;
	localparam logic [15:0] RST_PHASE_STEP = 16'd1;
	localparam logic [3:0] RST_BLOCK_SHIFT = 4'd6;
	localparam logic [3:0] MAX_BLOCK_SHIFT = 4'd8;

	// Delay multiples of the swing (Q2.12), left voices then right voices.
	localparam logic [13:0] VOICE_DELAY [NUM_VOICES] = '{
		14'd6185, 14'd8602, 14'd13722, 14'd6021, 14'd8806, 14'd13312
	};
	// LFO phase offsets in 1/65536 turn.
	localparam logic [15:0] VOICE_PHASE [NUM_VOICES] = '{
		16'd0, 16'd21904, 16'd43808, 16'd33377, 16'd55281, 16'd10430
	};

	typedef enum logic [2:0] {
		REG_VG_START    = 3'd0,
		REG_VG_STEP     = 3'd1,
		REG_MG_START    = 3'd2,
		REG_MG_STEP     = 3'd3,
		REG_TAP_RANGE   = 3'd4,
		REG_PHASE_STEP  = 3'd5,
		REG_BLOCK_SHIFT = 3'd6
	} cfg_reg_t;

	typedef logic signed [15:0] sine_rom_t [SINE_DEPTH];

	typedef struct packed {
		logic                accept;
		logic                reload;
		logic                clear_wr;
		logic                rom_p1;
		logic                s0_cap;
		logic                blk_mul;
		logic                blk_wr;
		logic                blk_last;
		logic                tap_a;
		logic                tap_b;
		logic                tap_m;
		logic                tap_s;
		logic                mem_wr;
		logic                mix_y;
		logic                mix_m;
		logic                done;
		logic [VOICE_W-1:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic blk_zero;
		logic out_busy;
	} sts_t;

	// Quarter-wave odd polynomial, mirrored and negated over the full turn.
	function automatic sine_rom_t build_sine();
		sine_rom_t tab;
		int u;
		int q;
		int r;
		int t;
		int t2;
		int w;
		int y;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			u = ((i * 65536) / SINE_DEPTH) & 16'hFFFF;
			q = u >> 14;
			r = u & 16'h3FFF;
			t = ((q & 1) != 0) ? (16384 - r) : r;
			t2 = (t * t) >> 14;
			w = ((21167 - ((2611 * t2) >> 14)) * t2) >> 14;
			y = ((51472 - w) * t) >> 14;
			if (y > 32767) begin
				y = 32767;
			end
			if ((q & 2) != 0) begin
				y = -y;
			end
			tab[i] = 16'(y);
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

// ===== sv/stereo_chorus_modulated_delay.sv =====
// ----------------------------------------------------------------------------
// Three-voice stereo chorus with modulated delay
// Channel   Handshake            Contents
// s_        tvalid/tready        tdata: smp_l, smp_r; tuser: func
// m_        tvalid/tready        tdata: out_l, out_r
// cfg_      we                   addr: register index; data: register value
//
// An audio transfer is taken in the idle state; its result is registered in
// the done state after three rounds of tap reads and the write and mix states,
// and no new item is taken before then. A block start adds the BSA, BSB, BMUL
// and BWR states per voice (sine table, multipliers). A reload transfer is
// taken in idle and gives no output. After reset both delay memories are cleared
// before input is taken; configuration writes are accepted throughout.
// A result waits in the output register while the next item is processed, and
// the next result holds in its last cycle until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_chorus_modulated_delay (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // smp_l, smp_r
	input  wire logic         s_tuser,   // func
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata,   // out_l, out_r
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_addr,
	input  wire logic [15:0]  cfg_data
);

	scmd_pkg::cmd_t cmd;
	scmd_pkg::sts_t sts;

	scmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scmd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ===== sv/scmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stereo chorus controller
// Sequences memory clearing, block starts, tap reads, mixing and output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_chorus_modulated_delay_defines.svh"

module scmd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	input  wire logic           s_tuser,
	output logic                s_tready,
	input  scmd_pkg::sts_t      sts,
	output scmd_pkg::cmd_t      cmd
);

	typedef enum logic [14:0] {
		ST_CLEAR = 15'h0001,
		ST_IDLE  = 15'h0002,
		ST_BSA   = 15'h0004,
		ST_BSB   = 15'h0008,
		ST_BMUL  = 15'h0010,
		ST_BWR   = 15'h0020,
		ST_TA    = 15'h0040,
		ST_TB    = 15'h0080,
		ST_TM    = 15'h0100,
		ST_TS    = 15'h0200,
		ST_WR    = 15'h0400,
		ST_MY    = 15'h0800,
		ST_MM    = 15'h1000,
		ST_DONE  = 15'h2000,
		ST_SPARE = 15'h4000
	} state_t;

	state_t state_q, state_d;
	logic [scmd_pkg::VOICE_W-1:0] idx_q, idx_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.idx = idx_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (s_tuser) begin
						cmd.reload = 1'b1;
					end else begin
						idx_d = '0;
						state_d = sts.blk_zero ? ST_BSA : ST_TA;
					end
				end
			end
			ST_BSA: begin
				state_d = ST_BSB;
			end
			ST_BSB: begin
				cmd.rom_p1 = 1'b1;
				cmd.s0_cap = 1'b1;
				state_d = ST_BMUL;
			end
			ST_BMUL: begin
				cmd.blk_mul = 1'b1;
				state_d = ST_BWR;
			end
			ST_BWR: begin
				cmd.blk_wr = 1'b1;
				if (idx_q == scmd_pkg::VOICE_W'(scmd_pkg::NUM_VOICES - 1)) begin
					cmd.blk_last = 1'b1;
					idx_d = '0;
					state_d = ST_TA;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = ST_BSA;
				end
			end
			ST_TA: begin
				cmd.tap_a = 1'b1;
				state_d = ST_TB;
			end
			ST_TB: begin
				cmd.tap_b = 1'b1;
				state_d = ST_TM;
			end
			ST_TM: begin
				cmd.tap_m = 1'b1;
				state_d = ST_TS;
			end
			ST_TS: begin
				cmd.tap_s = 1'b1;
				if (idx_q == scmd_pkg::VOICE_W'(scmd_pkg::NUM_TAPS - 1)) begin
					idx_d = '0;
					state_d = ST_WR;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = ST_TA;
				end
			end
			ST_WR: begin
				cmd.mem_wr = 1'b1;
				state_d = ST_MY;
			end
			ST_MY: begin
				cmd.mix_y = 1'b1;
				state_d = ST_MM;
			end
			ST_MM: begin
				cmd.mix_m = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

	`SCMD_ASSERT_NEXT(a_taps_to_write, (state_q == ST_TS) && (idx_q == 3'd2), state_q == ST_WR)
	`SCMD_ASSERT_NEXT(a_block_start, cmd.accept && !s_tuser && sts.blk_zero, state_q == ST_BSA)

endmodule

`default_nettype wire

// ===== sv/scmd_dp.sv =====
// ----------------------------------------------------------------------------
// Stereo chorus datapath
// Configuration, delay memories, sine table, tap state, gains and output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_chorus_modulated_delay_defines.svh"

module scmd_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  scmd_pkg::cmd_t     cmd,
	output scmd_pkg::sts_t     sts,
	input  wire logic [31:0]   s_tdata,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_addr,
	input  wire logic [15:0]   cfg_data,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [31:0]        m_tdata
);

	localparam int AW = scmd_pkg::DLY_AW;
	localparam int PW = scmd_pkg::POS_W;
	localparam int GW = scmd_pkg::GAIN_W;
	localparam scmd_pkg::sine_rom_t SINE_ROM = scmd_pkg::build_sine();

	logic [15:0] vg_start_q, mg_start_q, tap_range_q, phase_step_q;
	logic signed [15:0] vg_step_q, mg_step_q;
	logic [3:0] block_shift_q, bs;

	logic [AW-1:0] wp_q, clr_q;
	logic [15:0] lfo_q, p1_q, p_adv, ph;
	logic [PW-1:0] tap_pos_q [scmd_pkg::NUM_VOICES];
	logic [PW-1:0] tap_inc_q [scmd_pkg::NUM_VOICES];
	logic [GW-1:0] vg_q, mg_q;
	logic [7:0] bc_q;
	logic [8:0] bc_nx;
	logic out_valid_q;

	logic signed [15:0] in_l_q, in_r_q, rom_q, s0_q;
	logic [29:0] dr_q;
	logic signed [32:0] rs_q;
	logic signed [33:0] ri_q;
	logic signed [16:0] rng, sdiff;
	logic [PW-1:0] base_v, inc_v;

	logic signed [15:0] mem_l [scmd_pkg::DELAY_DEPTH];
	logic signed [15:0] mem_r [scmd_pkg::DELAY_DEPTH];
	logic signed [15:0] rd_l_q, rd_r_q, a_l_q, a_r_q;
	logic signed [33:0] ip_l_q, ip_r_q;
	logic signed [18:0] acc_l_q, acc_r_q;
	logic signed [43:0] vp_l_q, vp_r_q;
	logic signed [22:0] y_l_q, y_r_q;
	logic signed [47:0] mp_l_q, mp_r_q;
	logic signed [15:0] out_l_q, out_r_q;

	logic [2:0] tr;
	logic [PW-1:0] pos_l, pos_r;
	logic [AW-1:0] addr_l, addr_r;
	logic signed [16:0] dl, dr, fr_l, fr_r, tv_l, tv_r;

	function automatic logic [GW-1:0] ramp(input logic [GW-1:0] g,
			input logic signed [15:0] step);
		logic signed [GW+1:0] v;
		v = $signed({2'b00, g}) + step;
		if (v < 0) begin
			return '0;
		end else if (v > $signed({2'b00, scmd_pkg::GAIN_TOP})) begin
			return scmd_pkg::GAIN_TOP;
		end
		return v[GW-1:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] p);
		logic signed [25:0] z;
		z = 26'(p >>> 22);
		if (z > 26'sd32767) begin
			return 16'sh7FFF;
		end else if (z < -26'sd32768) begin
			return 16'sh8000;
		end
		return z[15:0];
	endfunction

	assign bs = (block_shift_q > scmd_pkg::MAX_BLOCK_SHIFT) ? scmd_pkg::MAX_BLOCK_SHIFT
		: block_shift_q;
	assign p_adv = phase_step_q << bs;
	assign ph = (cmd.rom_p1 ? p1_q : lfo_q) + scmd_pkg::VOICE_PHASE[cmd.idx];

	assign rng = $signed({1'b0, tap_range_q});
	assign sdiff = s0_q - rom_q;
	assign base_v = {wp_q, 16'h0000} - PW'(dr_q >> 4) - PW'(rs_q >>> 7);
	assign inc_v = PW'(ri_q >>> (5'd7 + bs)) + PW'(1 << 16);

	assign tr = cmd.idx + 3'd3;
	assign pos_l = tap_pos_q[cmd.idx];
	assign pos_r = tap_pos_q[tr];
	assign addr_l = cmd.tap_b ? pos_l[PW-1:16] + 1'b1 : pos_l[PW-1:16];
	assign addr_r = cmd.tap_b ? pos_r[PW-1:16] + 1'b1 : pos_r[PW-1:16];
	assign dl = rd_l_q - a_l_q;
	assign dr = rd_r_q - a_r_q;
	assign fr_l = $signed({1'b0, pos_l[15:0]});
	assign fr_r = $signed({1'b0, pos_r[15:0]});
	assign tv_l = 17'(a_l_q + (ip_l_q >>> 16));
	assign tv_r = 17'(a_r_q + (ip_r_q >>> 16));
	assign bc_nx = {1'b0, bc_q} + 9'd1;

	assign sts.clr_done = &clr_q;
	assign sts.blk_zero = (bc_q == 8'd0);
	assign sts.out_busy = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_r_q, out_l_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vg_start_q <= scmd_pkg::RST_VG_START;
			vg_step_q <= scmd_pkg::RST_VG_STEP;
			mg_start_q <= scmd_pkg::RST_MG_START;
			mg_step_q <= scmd_pkg::RST_MG_STEP;
			tap_range_q <= scmd_pkg::RST_TAP_RANGE;
			phase_step_q <= scmd_pkg::RST_PHASE_STEP;
			block_shift_q <= scmd_pkg::RST_BLOCK_SHIFT;
		end else if (cfg_we) begin
			unique case (scmd_pkg::cfg_reg_t'(cfg_addr))
				scmd_pkg::REG_VG_START: vg_start_q <= cfg_data;
				scmd_pkg::REG_VG_STEP: vg_step_q <= cfg_data;
				scmd_pkg::REG_MG_START: mg_start_q <= cfg_data;
				scmd_pkg::REG_MG_STEP: mg_step_q <= cfg_data;
				scmd_pkg::REG_TAP_RANGE: tap_range_q <= cfg_data;
				scmd_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data;
				scmd_pkg::REG_BLOCK_SHIFT: block_shift_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			clr_q <= '0;
			lfo_q <= '0;
			p1_q <= '0;
			vg_q <= '0;
			mg_q <= '0;
			bc_q <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < scmd_pkg::NUM_VOICES; k++) begin
				tap_pos_q[k] <= '0;
				tap_inc_q[k] <= '0;
			end
		end else begin
			if (cmd.clear_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.accept) begin
				if (cmd.reload) begin
					vg_q <= {vg_start_q, 8'h00};
					mg_q <= {mg_start_q, 8'h00};
				end else begin
					p1_q <= lfo_q + p_adv;
				end
			end
			if (cmd.blk_wr) begin
				tap_pos_q[cmd.idx] <= base_v;
				tap_inc_q[cmd.idx] <= inc_v;
			end
			if (cmd.blk_last) begin
				lfo_q <= p1_q;
			end
			if (cmd.done) begin
				out_valid_q <= 1'b1;
				wp_q <= wp_q + 1'b1;
				vg_q <= ramp(vg_q, vg_step_q);
				mg_q <= ramp(mg_q, mg_step_q);
				bc_q <= (bc_nx >= (9'd1 << bs)) ? 8'd0 : bc_nx[7:0];
				for (int k = 0; k < scmd_pkg::NUM_VOICES; k++) begin
					tap_pos_q[k] <= tap_pos_q[k] + tap_inc_q[k];
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= SINE_ROM[ph[15 -: scmd_pkg::SIN_AW]];
		if (cmd.s0_cap) begin
			s0_q <= rom_q;
		end
		if (cmd.blk_mul) begin
			dr_q <= scmd_pkg::VOICE_DELAY[cmd.idx] * tap_range_q;
			rs_q <= rng * s0_q;
			ri_q <= rng * sdiff;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			mem_l[clr_q] <= '0;
			mem_r[clr_q] <= '0;
		end else if (cmd.mem_wr) begin
			mem_l[wp_q] <= in_l_q;
			mem_r[wp_q] <= in_r_q;
		end
		rd_l_q <= mem_l[addr_l];
		rd_r_q <= mem_r[addr_r];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !cmd.reload) begin
			in_l_q <= s_tdata[15:0];
			in_r_q <= s_tdata[31:16];
			acc_l_q <= '0;
			acc_r_q <= '0;
		end
		if (cmd.tap_b) begin
			a_l_q <= rd_l_q;
			a_r_q <= rd_r_q;
		end
		if (cmd.tap_m) begin
			ip_l_q <= dl * fr_l;
			ip_r_q <= dr * fr_r;
		end
		if (cmd.tap_s) begin
			if (cmd.idx == 3'(scmd_pkg::MID_TAP)) begin
				acc_l_q <= acc_l_q + tv_l;
				acc_r_q <= acc_r_q + tv_r;
			end else begin
				acc_l_q <= acc_l_q - tv_l;
				acc_r_q <= acc_r_q - tv_r;
			end
		end
		if (cmd.mem_wr) begin
			vp_l_q <= $signed({1'b0, vg_q}) * acc_l_q;
			vp_r_q <= $signed({1'b0, vg_q}) * acc_r_q;
		end
		if (cmd.mix_y) begin
			y_l_q <= in_l_q + 23'(vp_l_q >>> 22);
			y_r_q <= in_r_q + 23'(vp_r_q >>> 22);
		end
		if (cmd.mix_m) begin
			mp_l_q <= $signed({1'b0, mg_q}) * y_l_q;
			mp_r_q <= $signed({1'b0, mg_q}) * y_r_q;
		end
		if (cmd.done) begin
			out_l_q <= sat16(mp_l_q);
			out_r_q <= sat16(mp_r_q);
		end
	end

	`SCMD_ASSERT_SAME(a_no_output_while_clearing, cmd.clear_wr, !out_valid_q)
	`SCMD_ASSERT_NEXT(a_done_loads_output, cmd.done, out_valid_q)

endmodule

`default_nettype wire
